FILE: rtl/svp_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and tables for the sprite view projection pipeline.
package svp_pkg;

  // CORDIC step count and unity-gain start vector (Q14)
  localparam int CORDIC_STEPS = 14;
  localparam int UNIT_X0      = 9949;

  // Arctangent table in binary-angle units, one entry per CORDIC step
  localparam logic [13:0] ARC_TABLE [CORDIC_STEPS] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
    14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
  };

  // Datapath widths
  localparam int VEC_W      = 27;  // vectoring x/y, differences scaled by 256
  localparam int ROT_W      = 17;  // rotation x/y in Q14, z in binary-angle units
  localparam int ROOT_TOP   = 32;  // first trial bit exponent of the square root
  localparam int ROOT_CELLS = 17;
  localparam int SIZE_Q     = 16;  // size quotient bits
  localparam int TERM_Q     = 20;  // column tangent quotient bits
  localparam int DIV1_W     = 64;
  localparam int DIV1_DW    = 48;
  localparam int DIV2_W     = 53;
  localparam int DIV2_DW    = 33;

  // Column tangent term limit
  localparam logic [19:0] BIG_TERM = 20'd1000000;

  // Configuration register indexes
  localparam logic REG_FIELD_OF_VIEW = 1'b0;
  localparam logic REG_VIEW_MARGIN   = 1'b1;

  // Vectoring CORDIC state
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic        [15:0]      z;
  } vec_t;

  // Rotation CORDIC state
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } rot_t;

  // Square root state: remainder and partial root
  typedef struct packed {
    logic [32:0] v;
    logic [33:0] r;
  } root_t;

  // Saturate to 16 bits signed
  function automatic logic [15:0] sat16(input logic signed [23:0] v);
    logic [15:0] res;
    if (v > 24'sd32767) begin
      res = 16'h7FFF;
    end else if (v < -24'sd32768) begin
      res = 16'h8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/svp_vec_cell.sv
`timescale 1ns / 1ps
// One vectoring CORDIC step: rotates the vector toward the x axis, sums the angle.
module svp_vec_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          en,
  input  svp_pkg::vec_t din,
  output svp_pkg::vec_t dout
);
  import svp_pkg::*;

  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  logic        [15:0]      step;

  assign xs   = din.x >>> IDX;
  assign ys   = din.y >>> IDX;
  assign step = 16'(ARC_TABLE[IDX]);

  // y above zero turns clockwise, otherwise counterclockwise
  always_ff @(posedge clk) begin
    if (en) begin
      if (din.y > 0) begin
        dout.x <= din.x + ys;
        dout.y <= din.y - xs;
        dout.z <= din.z + step;
      end else begin
        dout.x <= din.x - ys;
        dout.y <= din.y + xs;
        dout.z <= din.z - step;
      end
    end
  end

endmodule

FILE: rtl/svp_rot_cell.sv
`timescale 1ns / 1ps
// One rotation CORDIC step: turns the vector by the table angle toward z = 0.
module svp_rot_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          en,
  input  svp_pkg::rot_t din,
  output svp_pkg::rot_t dout
);
  import svp_pkg::*;

  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;
  logic signed [ROT_W-1:0] step;

  assign xs   = din.x >>> IDX;
  assign ys   = din.y >>> IDX;
  assign step = ROT_W'(ARC_TABLE[IDX]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (din.z >= 0) begin
        dout.x <= din.x - ys;
        dout.y <= din.y + xs;
        dout.z <= din.z - step;
      end else begin
        dout.x <= din.x + ys;
        dout.y <= din.y - xs;
        dout.z <= din.z + step;
      end
    end
  end

endmodule

FILE: rtl/svp_root_cell.sv
`timescale 1ns / 1ps
// One digit of the integer square root: trial subtract at a fixed bit pair.
module svp_root_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           en,
  input  svp_pkg::root_t din,
  output svp_pkg::root_t dout
);
  import svp_pkg::*;

  localparam int SH = ROOT_TOP - 2 * IDX;

  logic [33:0] bit_v;
  logic [33:0] trial;

  assign bit_v = 34'(1) << SH;
  assign trial = din.r + bit_v;

  always_ff @(posedge clk) begin
    if (en) begin
      if ({1'b0, din.v} >= trial) begin
        dout.v <= din.v - trial[32:0];
        dout.r <= (din.r >> 1) + bit_v;
      end else begin
        dout.v <= din.v;
        dout.r <= din.r >> 1;
      end
    end
  end

endmodule

FILE: rtl/svp_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step: one quotient bit at a fixed weight.
module svp_div_cell #(
  parameter int W  = 64,
  parameter int DW = 48,
  parameter int QW = 16,
  parameter int B  = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  rem_in,
  input  logic [DW-1:0] dvs_in,
  input  logic [QW-1:0] q_in,
  output logic [W-1:0]  rem_out,
  output logic [DW-1:0] dvs_out,
  output logic [QW-1:0] q_out
);

  logic [W-1:0] dsh;

  assign dsh = W'(dvs_in) << B;

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_out <= dvs_in;
      if (rem_in >= dsh) begin
        rem_out <= rem_in - dsh;
        q_out   <= {q_in[QW-2:0], 1'b1};
      end else begin
        rem_out <= rem_in;
        q_out   <= {q_in[QW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/sprite_view_projection_top.sv
`timescale 1ns / 1ps
// Sprite view projection: bearing, visibility, distance, size, rows and columns.
// Throughput: one beat per cycle while the output is not stalled; the fixed-length cell chains set the latency.
// A stalled output holds the beat pipeline, but not the free-running half-angle chain; s_tready follows it.
// Reset (rst, synchronous) clears all valid bits and loads the view registers.
// The sine/cosine of half the view angle settle after a register write through the half-angle cells and clamp register.
module sprite_view_projection_top #(
  parameter int SCREEN_COLUMNS = 1024,
  parameter int SCREEN_ROWS    = 512,
  parameter int TILE_SIZE      = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // sprite_x, sprite_y, viewer_x, viewer_y, viewer_heading
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // sprite_distance, angle_offset, projected_size, top_row, bottom_row,
  // left_column, right_column, zero fill
  output logic [103:0] m_tdata,
  // visible
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [14:0]  cfg_data
);
  import svp_pkg::*;

  localparam int          HALF_COLS = SCREEN_COLUMNS / 2;
  localparam int          HALF_ROWS = SCREEN_ROWS / 2;
  localparam logic [19:0] KSIZE     = 20'(TILE_SIZE * (SCREEN_COLUMNS / 2));
  localparam logic [11:0] HCOLS12   = 12'(SCREEN_COLUMNS / 2);

  // Configuration registers
  logic [14:0] field_of_view;
  logic [12:0] view_margin;

  // Pipeline control
  logic        en;
  logic        vld [0:53];

  // Stage 0
  logic signed [16:0] dx0, dy0;
  logic signed [16:0] dx_w, dy_w, xa_w, ya_w;
  logic        [15:0] head_d [0:14];
  logic               zero_d [1:14];

  // Bearing chain
  vec_t vec [0:14];

  // Stage 15
  logic [15:0] bear_w, wrapped_w, off_w;
  logic [16:0] lim_w;
  logic        vis_w;
  logic [15:0] s15;
  logic        vis_d [15:53];
  logic [15:0] off_d [15:53];

  // Rotation chain for the offset
  logic signed [ROT_W-1:0] se_w, a_w;
  logic                    flip_w;
  logic                    flip_d [16:29];
  rot_t                    rot [0:14];

  // View half-angle chain, free running
  rot_t        hrot [0:14];
  logic [14:0] cos_h, sin_h;

  // Square root chain
  logic [31:0] sqx_1, sqy_1;
  root_t       root [0:ROOT_CELLS];
  root_t       root_2;
  logic [16:0] dist_d [20:53];

  // Stage 29..31
  logic signed [ROT_W-1:0] cos_s, sin_s;
  logic [31:0]             p1_30;
  logic [34:0]             nk_30;
  logic signed [32:0]      nt_30, dt_30;
  logic [15:0]             cs_30;
  logic                    sat_d [30:52];
  logic [47:0]             d_31;
  logic [34:0]             nk_31;
  logic signed [44:0]      tn_31;
  logic signed [32:0]      den_31;

  // Dividers
  logic [DIV1_W-1:0]  rem1 [0:SIZE_Q];
  logic [DIV1_DW-1:0] dv1  [0:SIZE_Q];
  logic [SIZE_Q-1:0]  q1   [0:SIZE_Q];
  logic [DIV2_W-1:0]  rem2 [0:TERM_Q];
  logic [DIV2_DW-1:0] dv2  [0:TERM_Q];
  logic [TERM_Q-1:0]  q2   [0:TERM_Q];
  logic [DIV1_W-1:0]  n_w;
  logic [44:0]        anum_w;
  logic [DIV2_DW-1:0] aden_w;
  logic               ovf1_d [32:52];
  logic               ovf2_d [32:52];
  logic               neg_d  [32:52];
  logic               nz_d   [32:52];
  logic [SIZE_Q-1:0]  q1_d   [49:52];

  // Stage 53 and output
  logic [19:0]        mag_w;
  logic [15:0]        size53;
  logic signed [21:0] term53;
  logic [14:0]        half_w;
  logic signed [17:0] top_w;
  logic [17:0]        bot_w;
  logic [9:0]         top_f, bot_f;
  logic signed [23:0] left_w, right_w;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_of_view <= 15'd10923;
      view_margin   <= 13'd2086;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIELD_OF_VIEW: field_of_view <= cfg_data;
        REG_VIEW_MARGIN:   view_margin   <= cfg_data[12:0];
      endcase
    end
  end

  // Valid bits along the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= 53; k++) vld[k] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k <= 53; k++) vld[k] <= vld[k-1];
      m_tvalid <= vld[53];
    end
  end

  // Input differences
  assign dx_w = $signed({1'b0, s_tdata[15:0]})  - $signed({1'b0, s_tdata[47:32]});
  assign dy_w = $signed({1'b0, s_tdata[31:16]}) - $signed({1'b0, s_tdata[63:48]});

  // Half-turn pre-rotation into the bearing chain
  assign xa_w = dx0[16] ? -dx0 : dx0;
  assign ya_w = dx0[16] ? -dy0 : dy0;
  assign vec[0].x = {{2{xa_w[16]}}, xa_w, 8'b0};
  assign vec[0].y = {{2{ya_w[16]}}, ya_w, 8'b0};
  assign vec[0].z = dx0[16] ? 16'h8000 : 16'h0000;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    svp_vec_cell #(.IDX(k)) u_cell (.clk(clk), .en(en), .din(vec[k]), .dout(vec[k+1]));
  end

  // Offset from heading and visibility test
  assign bear_w    = zero_d[14] ? 16'h0000 : vec[14].z;
  assign wrapped_w = head_d[14] - bear_w;
  assign off_w     = wrapped_w[15] ? (16'h0000 - wrapped_w) : wrapped_w;
  assign lim_w     = 17'(field_of_view[14:1]) + 17'(view_margin);
  assign vis_w     = {1'b0, off_w} < lim_w;

  // Fold the offset into a quarter turn for the rotation chain
  assign se_w = {s15[15], s15};
  always_comb begin
    flip_w = 1'b0;
    a_w    = se_w;
    if (se_w > 17'sd16384) begin
      a_w    = se_w - 17'sd32768;
      flip_w = 1'b1;
    end else if (se_w < -17'sd16384) begin
      a_w    = se_w + 17'sd32768;
      flip_w = 1'b1;
    end
  end
  assign rot[0].x = ROT_W'(UNIT_X0);
  assign rot[0].y = '0;
  assign rot[0].z = a_w;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    svp_rot_cell #(.IDX(k)) u_cell (.clk(clk), .en(en), .din(rot[k]), .dout(rot[k+1]));
  end

  // Half view angle chain runs every cycle on the register value
  assign hrot[0].x = ROT_W'(UNIT_X0);
  assign hrot[0].y = '0;
  assign hrot[0].z = ROT_W'(field_of_view[14:1]);

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_hrot
    svp_rot_cell #(.IDX(k)) u_cell (.clk(clk), .en(1'b1), .din(hrot[k]), .dout(hrot[k+1]));
  end

  // Clamp the half-angle sine and cosine
  always_ff @(posedge clk) begin
    cos_h <= hrot[14].x[16] ? 15'd0 : hrot[14].x[14:0];
    sin_h <= (hrot[14].y < 17'sd1) ? 15'd1 : hrot[14].y[14:0];
  end

  // Square root chain
  assign root[0] = root_2;
  for (genvar k = 0; k < ROOT_CELLS; k++) begin : g_root
    svp_root_cell #(.IDX(k)) u_cell (.clk(clk), .en(en), .din(root[k]), .dout(root[k+1]));
  end

  // Cosine and sine of the offset, negated back where the offset was folded
  assign cos_s = flip_d[29] ? -rot[14].x : rot[14].x;
  assign sin_s = flip_d[29] ? -rot[14].y : rot[14].y;

  // Divider setup
  assign n_w    = DIV1_W'({nk_31, 18'b0});
  assign anum_w = tn_31[44] ? 45'(-tn_31) : 45'(tn_31);
  assign aden_w = den_31[32] ? 33'(-den_31) : 33'(den_31);

  for (genvar k = 0; k < SIZE_Q; k++) begin : g_div1
    svp_div_cell #(.W(DIV1_W), .DW(DIV1_DW), .QW(SIZE_Q), .B(SIZE_Q - 1 - k)) u_cell (
      .clk(clk), .en(en),
      .rem_in(rem1[k]), .dvs_in(dv1[k]), .q_in(q1[k]),
      .rem_out(rem1[k+1]), .dvs_out(dv1[k+1]), .q_out(q1[k+1])
    );
  end

  for (genvar k = 0; k < TERM_Q; k++) begin : g_div2
    svp_div_cell #(.W(DIV2_W), .DW(DIV2_DW), .QW(TERM_Q), .B(TERM_Q - 1 - k)) u_cell (
      .clk(clk), .en(en),
      .rem_in(rem2[k]), .dvs_in(dv2[k]), .q_in(q2[k]),
      .rem_out(rem2[k+1]), .dvs_out(dv2[k+1]), .q_out(q2[k+1])
    );
  end

  // Clamped magnitude of the column tangent term
  assign mag_w = ovf2_d[52] ? BIG_TERM :
                 ((q2[TERM_Q] > BIG_TERM) ? BIG_TERM : q2[TERM_Q]);

  // Rows and columns
  assign half_w  = size53[15:1];
  assign top_w   = 18'(HALF_ROWS) - 18'(half_w);
  assign bot_w   = 18'(HALF_ROWS) + 18'(half_w);
  assign top_f   = top_w[17] ? 10'd0 : top_w[9:0];
  assign bot_f   = (bot_w > 18'(SCREEN_ROWS)) ? 10'(SCREEN_ROWS) : bot_w[9:0];
  assign left_w  = 24'(HALF_COLS) + 24'(term53) - 24'(half_w);
  assign right_w = left_w + 24'(size53);

  // Datapath registers, all held while the output stalls
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0
      dx0       <= dx_w;
      dy0       <= dy_w;
      head_d[0] <= s_tdata[79:64];
      zero_d[1] <= (dx0 == 17'sd0) && (dy0 == 17'sd0);
      for (int k = 1; k <= 14; k++) head_d[k] <= head_d[k-1];
      for (int k = 2; k <= 14; k++) zero_d[k] <= zero_d[k-1];

      // distance squares and sum
      sqx_1    <= 32'(dx0 * dx0);
      sqy_1    <= 32'(dy0 * dy0);
      root_2.v <= {1'b0, sqx_1} + {1'b0, sqy_1};
      root_2.r <= '0;
      dist_d[20] <= root[ROOT_CELLS].r[16:0];
      for (int k = 21; k <= 53; k++) dist_d[k] <= dist_d[k-1];

      // stage 15
      s15        <= wrapped_w;
      vis_d[15]  <= vis_w;
      off_d[15]  <= off_w;
      for (int k = 16; k <= 53; k++) begin
        vis_d[k] <= vis_d[k-1];
        off_d[k] <= off_d[k-1];
      end
      flip_d[16] <= flip_w;
      for (int k = 17; k <= 29; k++) flip_d[k] <= flip_d[k-1];

      // stage 30: first products
      p1_30      <= 32'(sin_h) * 32'(dist_d[29]);
      nk_30      <= 35'(KSIZE) * 35'(cos_h);
      nt_30      <= $signed({1'b0, cos_h}) * sin_s;
      dt_30      <= $signed({1'b0, sin_h}) * cos_s;
      cs_30      <= cos_s[15:0];
      sat_d[30]  <= (dist_d[29] == 17'd0) || (cos_s <= 17'sd0);
      for (int k = 31; k <= 52; k++) sat_d[k] <= sat_d[k-1];

      // stage 31: second products
      d_31   <= 48'(p1_30) * 48'(cs_30);
      nk_31  <= nk_30;
      tn_31  <= -($signed({1'b0, HCOLS12}) * nt_30);
      den_31 <= dt_30;

      // stage 32: divider entry and overflow checks
      rem1[0]    <= n_w;
      dv1[0]     <= d_31;
      q1[0]      <= '0;
      ovf1_d[32] <= n_w >= {d_31, 16'b0};
      rem2[0]    <= DIV2_W'(anum_w);
      dv2[0]     <= aden_w;
      q2[0]      <= '0;
      ovf2_d[32] <= DIV2_W'(anum_w) >= {aden_w, 20'b0};
      neg_d[32]  <= tn_31[44] ^ den_31[32];
      nz_d[32]   <= tn_31 != 45'sd0;
      for (int k = 33; k <= 52; k++) begin
        ovf1_d[k] <= ovf1_d[k-1];
        ovf2_d[k] <= ovf2_d[k-1];
        neg_d[k]  <= neg_d[k-1];
        nz_d[k]   <= nz_d[k-1];
      end
      q1_d[49] <= q1[SIZE_Q];
      for (int k = 50; k <= 52; k++) q1_d[k] <= q1_d[k-1];

      // stage 53
      size53 <= (sat_d[52] || ovf1_d[52]) ? 16'hFFFF : q1_d[52];
      if (!nz_d[52]) begin
        term53 <= '0;
      end else if (neg_d[52]) begin
        term53 <= -$signed({2'b0, mag_w});
      end else begin
        term53 <= $signed({2'b0, mag_w});
      end

      // output register
      m_tuser          <= vis_d[53];
      m_tdata[32:17]   <= off_d[53];
      m_tdata[103:101] <= 3'b0;
      if (vis_d[53]) begin
        m_tdata[16:0]  <= dist_d[53];
        m_tdata[48:33] <= size53;
        m_tdata[58:49] <= top_f;
        m_tdata[68:59] <= bot_f;
        m_tdata[84:69] <= sat16(left_w);
        m_tdata[100:85] <= sat16(right_w);
      end else begin
        m_tdata[16:0]   <= '0;
        m_tdata[48:33]  <= '0;
        m_tdata[58:49]  <= '0;
        m_tdata[68:59]  <= '0;
        m_tdata[84:69]  <= '0;
        m_tdata[100:85] <= '0;
      end
    end
  end

endmodule

FILE: rtl/svp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sprite view projection top, bound to it.
module svp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [79:0]  s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic         m_tuser,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic         cfg_index,
  input logic [14:0]  cfg_data
);

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat after reset");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // A stalled output holds the input side too
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // Hidden sprite: everything but the offset is zero
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[16:0] == 17'd0 && m_tdata[100:33] == 68'd0)
    else $error("hidden sprite with nonzero fields");

  // Visible sprite at zero distance gets the saturated size
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tdata[16:0] == 17'd0 |-> m_tdata[48:33] == 16'hFFFF)
    else $error("zero distance without saturated size");

endmodule

bind sprite_view_projection_top svp_checker u_svp_checker (.*);
